/* rtl/mpde_pkg.sv */
// Shared types, constants and encode tables for the mask preview display encoder.
`timescale 1ns / 1ps

package mpde_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int PIX_W   = 16;
    localparam int POS_W   = 13;
    localparam int SIZE_W  = 11;
    localparam int DIV_W   = SIZE_W + 1;
    localparam int CLR_W   = 36;
    localparam int CH_W    = 12;
    localparam int W_W     = PIX_W + 1;
    localparam int DIFF_W  = PIX_W + 2;
    localparam int PROD_W  = DIFF_W + W_W;
    localparam int PR_W    = 34;
    localparam int THR_W   = FRAC_BITS + 1;
    localparam int SRCH    = 8;
    localparam int LANES   = 3;
    localparam int IDX_W   = 3;

    localparam int DIV_STAGES = POS_W;
    localparam int PIPE_LAT   = DIV_STAGES + 2 + 2 + SRCH + 1;

    localparam longint LIN_END  = (longint'(31308) << FRAC_BITS) / 64'd10000000;
    localparam int     LIN_BITS = $clog2(LIN_END + 1);

    localparam int GREY_R = 19661;
    localparam int GREY_G = 38666;
    localparam int GREY_B = 7209;

    localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ALPHA   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREY    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE    = 3'd3;
    localparam logic [IDX_W-1:0] REG_COLOR_A = 3'd4;
    localparam logic [IDX_W-1:0] REG_COLOR_B = 3'd5;

    localparam logic [1:0] MODE_COPY   = 2'd0;
    localparam logic [1:0] MODE_MASK   = 2'd1;
    localparam logic [1:0] MODE_CHAN   = 2'd2;
    // spare code, behaves as copy
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [PIX_W-1:0] red;
        logic signed [PIX_W-1:0] green;
        logic signed [PIX_W-1:0] blue;
        logic signed [PIX_W-1:0] mask;
        logic [POS_W-1:0]        column;
        logic [POS_W-1:0]        row;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } result_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] p;
        logic [FRAC_BITS:0]      chk;
        logic signed [W_W-1:0]   w;
        logic                    copy;
    } lane_in_t;

    typedef logic [THR_W-1:0] thr_tab_t [256];
    typedef logic [7:0] lin_tab_t [2**LIN_BITS];

    // exact test of 255*(1.055*(v/ONE)^(5/12) - 0.055) >= k - 0.5
    function automatic logic pow_test(longint v, longint k);
        logic [319:0] lhs;
        logic [319:0] rhs;
        longint n;
        n = (2 * k - 1) * 1000 + 28050;
        lhs = 320'd1;
        rhs = 320'd1;
        for (int i = 0; i < 5; i++) lhs = lhs * 320'(v);
        for (int i = 0; i < 12; i++) lhs = lhs * 320'd538050;
        for (int i = 0; i < 12; i++) rhs = rhs * 320'(n);
        for (int i = 0; i < 5; i++) rhs = rhs << FRAC_BITS;
        return lhs >= rhs;
    endfunction

    function automatic thr_tab_t build_thr();
        thr_tab_t t;
        longint lo;
        longint hi;
        longint mid;
        t[0] = '0;
        for (int k = 1; k < 256; k++) begin
            lo = LIN_END + 1;
            hi = ONE;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (pow_test(mid, k)) hi = mid;
                else lo = mid + 1;
            end
            t[k] = THR_W'(lo);
        end
        return t;
    endfunction

    function automatic lin_tab_t build_lin();
        lin_tab_t t;
        longint r;
        for (int v = 0; v < 2**LIN_BITS; v++) begin
            r = (longint'(32946) * v + 5 * ONE) / (10 * ONE);
            t[v] = (r > 255) ? 8'd255 : 8'(r);
        end
        return t;
    endfunction

    localparam thr_tab_t THR_TAB = build_thr();
    localparam lin_tab_t LIN_TAB = build_lin();

    // 12-bit colour fraction into FRAC_BITS fixed point
    function automatic logic [FRAC_BITS:0] chk_fix(logic [CH_W-1:0] c);
        logic [FRAC_BITS+CH_W-1:0] t;
        t = {c, {FRAC_BITS{1'b0}}};
        return (FRAC_BITS + 1)'(t >> CH_W);
    endfunction

endpackage

/* rtl/mask_preview_display_encoder.sv */
// Top level of the mask preview display encoder: config, checker, lanes, merge.
`timescale 1ns / 1ps
//
// Usage
//  pixel channel: pixel_valid / pixel_stall / pixel carries one linear RGB
//   pixel with mask and raster position. A request is taken at an edge with
//   pixel_valid high and pixel_stall low.
//  result channel: result_valid / result_stall / result carries the blue,
//   green and red bytes, in input order, one per pixel.
//  cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data writes one
//   register; cfg_ready is always high. Write only while the block is empty.
//  Pipeline: 26 stages; the result of a pixel is registered in the last stage.
//   Throughput: one pixel per clock while the result is not stalled.
//  Depth set by the 13-stage position remainder units and the 8-stage
//   sRGB threshold search in each colour lane.
//  Stall: a stalled result freezes the whole pipeline; pixel_stall goes high
//   in the same cycle and no pixel is lost.
//  Reset: pipeline empty, mode copy, checker size 2, both colours black.
//

module mask_preview_display_encoder
    import mpde_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  pixel_t           pixel,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CLR_W-1:0] cfg_data
);

    logic [1:0]        mode_reg;
    logic              alpha_en_reg;
    logic              grey_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CLR_W-1:0]  color_a_reg;
    logic [CLR_W-1:0]  color_b_reg;

    logic [PIPE_LAT-1:0] vld_reg;
    logic                adv;

    logic [SIZE_W-1:0] sz;
    logic [DIV_W-1:0]  period;
    logic [DIV_W-1:0]  rem_col;
    logic [DIV_W-1:0]  rem_row;

    pixel_t pix_dly_reg [DIV_STAGES];

    pixel_t                  g_pix_reg;
    logic [CLR_W-1:0]        g_clr_reg;
    logic signed [W_W-1:0]   g_w_reg;
    logic signed [PR_W-1:0]  g_gr_reg;
    logic signed [PR_W-1:0]  g_gg_reg;
    logic signed [PR_W-1:0]  g_gb_reg;

    logic [CLR_W-1:0]        clr_next;
    logic signed [W_W-1:0]   w_next;
    logic signed [PIX_W-1:0] mc;
    logic                    fx;
    logic                    fy;

    lane_in_t                hin_reg  [LANES];
    lane_in_t                hin_next [LANES];
    logic signed [PR_W+1:0]  ysum;
    logic signed [PIX_W-1:0] y;
    logic [7:0]              enc [LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_COPY;
            alpha_en_reg <= 1'b0;
            grey_reg     <= 1'b0;
            size_reg     <= SIZE_W'(2);
            color_a_reg  <= '0;
            color_b_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg     <= cfg_data[1:0];
                REG_ALPHA:   alpha_en_reg <= cfg_data[0];
                REG_GREY:    grey_reg     <= cfg_data[0];
                REG_SIZE:    size_reg     <= cfg_data[SIZE_W-1:0];
                REG_COLOR_A: color_a_reg  <= cfg_data;
                REG_COLOR_B: color_b_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // global advance: only a stalled result holds the pipe
    assign adv         = !(vld_reg[PIPE_LAT-1] && result_stall);
    assign pixel_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], pixel_valid};
        end
    end

    assign sz     = (size_reg < SIZE_W'(2)) ? SIZE_W'(2) : size_reg;
    assign period = {sz, 1'b0};

    mpde_rem u_rem_col (
        .clk     (clk),
        .en      (adv),
        .value   (pixel.column),
        .divisor (period),
        .rem     (rem_col)
    );

    mpde_rem u_rem_row (
        .clk     (clk),
        .en      (adv),
        .value   (pixel.row),
        .divisor (period),
        .rem     (rem_row)
    );

    always_comb
    begin
        fx = rem_col >= {1'b0, sz};
        fy = rem_row >= {1'b0, sz};
        clr_next = (fx == fy) ? color_b_reg : color_a_reg;

        mc = pix_dly_reg[DIV_STAGES-1].mask;
        if (mc < 0)
        begin
            mc = '0;
        end
        else if (mc > ONE)
        begin
            mc = PIX_W'(ONE);
        end

        case (mode_reg)
            MODE_MASK: w_next = W_W'(ONE) - W_W'(mc);
            MODE_CHAN: w_next = alpha_en_reg ? W_W'(pix_dly_reg[DIV_STAGES-1].mask) : '0;
            default:   w_next = '0;
        endcase
    end

    // luma rounded half up
    always_comb
    begin
        ysum = (PR_W+2)'(g_gr_reg) + (PR_W+2)'(g_gg_reg) + (PR_W+2)'(g_gb_reg)
             + (PR_W+2)'(1 << 15);
        y = PIX_W'(ysum >>> 16);
    end

    always_comb
    begin
        logic signed [PIX_W-1:0] own;
        for (int l = 0; l < LANES; l++)
        begin
            own = (l == 0) ? g_pix_reg.blue : ((l == 1) ? g_pix_reg.green : g_pix_reg.red);
            case (mode_reg)
                MODE_MASK: hin_next[l].p = grey_reg ? y : own;
                MODE_CHAN: hin_next[l].p = g_pix_reg.green;
                default:   hin_next[l].p = own;
            endcase
            hin_next[l].chk  = chk_fix(g_clr_reg[(LANES-1-l)*CH_W +: CH_W]);
            hin_next[l].w    = g_w_reg;
            hin_next[l].copy = (mode_reg != MODE_MASK) && (mode_reg != MODE_CHAN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_dly_reg[0] <= pixel;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                pix_dly_reg[s] <= pix_dly_reg[s-1];
            end
            g_pix_reg <= pix_dly_reg[DIV_STAGES-1];
            g_clr_reg <= clr_next;
            g_w_reg   <= w_next;
            g_gr_reg  <= PR_W'(pix_dly_reg[DIV_STAGES-1].red) * PR_W'(GREY_R);
            g_gg_reg  <= PR_W'(pix_dly_reg[DIV_STAGES-1].green) * PR_W'(GREY_G);
            g_gb_reg  <= PR_W'(pix_dly_reg[DIV_STAGES-1].blue) * PR_W'(GREY_B);
            for (int l = 0; l < LANES; l++)
            begin
                hin_reg[l] <= hin_next[l];
            end
            result.out_blue  <= enc[0];
            result.out_green <= enc[1];
            result.out_red   <= enc[2];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mpde_lane u_lane (
            .clk (clk),
            .en  (adv),
            .din (hin_reg[l]),
            .enc (enc[l])
        );
    end

    assign result_valid = vld_reg[PIPE_LAT-1];

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> pixel_stall)
        else $error("pixel taken while result stalled");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_output_only_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall) |=> ($past(vld_reg[PIPE_LAT-2]) == result_valid))
        else $error("result valid lost or invented");
`endif

endmodule

/* rtl/mpde_rem.sv */
// Pipelined restoring remainder unit: one quotient bit per stage.
`timescale 1ns / 1ps

module mpde_rem
    import mpde_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [POS_W-1:0] value,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] rem
);

    logic [DIV_W-1:0] rem_reg  [DIV_STAGES];
    logic [POS_W-1:0] val_reg  [DIV_STAGES];
    logic [DIV_W-1:0] rem_next [DIV_STAGES];
    logic [POS_W-1:0] val_next [DIV_STAGES];

    always_comb
    begin
        logic [DIV_W-1:0] r_in;
        logic [POS_W-1:0] v_in;
        logic [DIV_W:0]   t;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            r_in = (s == 0) ? '0 : rem_reg[(s == 0) ? 0 : s - 1];
            v_in = (s == 0) ? value : val_reg[(s == 0) ? 0 : s - 1];
            t = {r_in, v_in[POS_W-1]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            rem_next[s] = t[DIV_W-1:0];
            val_next[s] = {v_in[POS_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                val_reg[s] <= val_next[s];
            end
        end
    end

    assign rem = rem_reg[DIV_STAGES-1];

endmodule

/* rtl/mpde_lane.sv */
// One colour lane: checker blend, saturation and sRGB / copy byte encode.
`timescale 1ns / 1ps

module mpde_lane
    import mpde_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  lane_in_t din,
    output logic [7:0] enc
);

    localparam int SUM_W = PROD_W + 1;
    localparam int CP_W  = PIX_W + 8;

    logic signed [PIX_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     copy1_reg;

    logic signed [PIX_W-1:0]  v2_reg;
    logic [7:0]               pre2_reg;
    logic                     srch2_reg;

    logic [THR_W-1:0] sv_reg  [SRCH];
    logic [7:0]       sn_reg  [SRCH];
    logic [7:0]       spre_reg[SRCH];
    logic             ssr_reg [SRCH];
    logic [7:0]       sn_next [SRCH];

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sh;
    logic signed [PIX_W-1:0]  v_next;
    logic [CP_W-1:0]          cpos;
    logic [CP_W-1:0]          cp;
    logic [7:0]               copy_b;
    logic [7:0]               srgb_pre;
    logic [7:0]               pre_next;
    logic                     srch_next;

    // p*(ONE-w) + chk*w folded as p*ONE + (chk-p)*w
    always_comb
    begin
        diff = DIFF_W'(signed'({1'b0, din.chk})) - DIFF_W'(din.p);
        prod_next = diff * din.w;
    end

    always_comb
    begin
        sum = (SUM_W'(p1_reg) <<< FRAC_BITS) + SUM_W'(prod_reg) + SUM_W'(ONE / 2);
        sh  = sum >>> FRAC_BITS;
        if (sh > SUM_W'(32767))
        begin
            v_next = 16'sh7FFF;
        end
        else if (sh < -SUM_W'(32768))
        begin
            v_next = 16'sh8000;
        end
        else
        begin
            v_next = PIX_W'(sh);
        end

        cpos = (p1_reg < 0) ? '0 : CP_W'(p1_reg[PIX_W-2:0]);
        cp = (((cpos << 8) - cpos) + CP_W'(ONE / 2)) >> FRAC_BITS;
        copy_b = (cp > CP_W'(255)) ? 8'd255 : cp[7:0];

        if (v_next <= 0)
        begin
            srgb_pre = 8'd0;
        end
        else if (v_next >= ONE)
        begin
            srgb_pre = 8'd255;
        end
        else
        begin
            srgb_pre = LIN_TAB[v_next[LIN_BITS-1:0]];
        end

        pre_next  = copy1_reg ? copy_b : srgb_pre;
        srch_next = !copy1_reg && (v_next > LIN_END) && (v_next < ONE);
    end

    // binary search over the monotone threshold table, one bit a stage
    always_comb
    begin
        logic [7:0]       n_in;
        logic [7:0]       cand;
        logic [THR_W-1:0] v_in;
        for (int s = 0; s < SRCH; s++)
        begin
            n_in = (s == 0) ? 8'd0 : sn_reg[(s == 0) ? 0 : s - 1];
            v_in = (s == 0) ? v2_reg[THR_W-1:0] : sv_reg[(s == 0) ? 0 : s - 1];
            cand = n_in | (8'h80 >> s);
            sn_next[s] = (THR_TAB[cand] <= v_in) ? cand : n_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= din.p;
            prod_reg  <= prod_next;
            copy1_reg <= din.copy;
            v2_reg    <= v_next;
            pre2_reg  <= pre_next;
            srch2_reg <= srch_next;
            sv_reg[0]   <= v2_reg[THR_W-1:0];
            spre_reg[0] <= pre2_reg;
            ssr_reg[0]  <= srch2_reg;
            for (int s = 1; s < SRCH; s++)
            begin
                sv_reg[s]   <= sv_reg[s-1];
                spre_reg[s] <= spre_reg[s-1];
                ssr_reg[s]  <= ssr_reg[s-1];
            end
            for (int s = 0; s < SRCH; s++)
            begin
                sn_reg[s] <= sn_next[s];
            end
        end
    end

    assign enc = ssr_reg[SRCH-1] ? sn_reg[SRCH-1] : spre_reg[SRCH-1];

endmodule
